// ----- hdl/audio_stream_ring_device_macros.svh -----
// Assertion macros shared by the audio stream ring device RTL.
`ifndef AUDIO_STREAM_RING_DEVICE_MACROS_SVH
`define AUDIO_STREAM_RING_DEVICE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define ASRD_ASSERT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("asrd check failed");
// Next-cycle implication.
`define ASRD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("asrd check failed");
`else
`define ASRD_ASSERT(lbl, clk, rst, ante, cons)
`define ASRD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- hdl/asrd_pkg.sv -----
package asrd_pkg;

   localparam int unsigned DEF_BUFFER_BYTES = 65536;
   localparam int unsigned DEF_MAX_DRAIN    = 64;
   localparam int unsigned QUEUE_DEPTH      = 4;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned ADDR_W = 16;
   localparam int unsigned LEN_W  = 7;
   localparam int unsigned IDX_W  = 3;
   localparam int unsigned ACT_W  = 3;
   localparam int unsigned BYTE_W = 8;

   localparam int unsigned NUM_REGS  = 6;
   localparam int unsigned IDX_SIZE  = 3;
   localparam int unsigned IDX_INIT  = 4;
   localparam int unsigned IDX_COUNT = 5;

   typedef enum logic [ACT_W-1:0] {
      ACT_REG_WR = 3'd0,
      ACT_REG_RD = 3'd1,
      ACT_BUF_WR = 3'd2,
      ACT_BUF_RD = 3'd3,
      ACT_DRAIN  = 3'd4
   } action_type;

   // Commands after classification in the front part.
   typedef enum logic [2:0] {
      OP_REG_WR,
      OP_REG_RD,
      OP_ZERO_RD,
      OP_BUF_WR,
      OP_BUF_RD,
      OP_DRAIN
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [IDX_W-1:0]  reg_index;
      logic [ADDR_W-1:0] buf_address;
      logic [DATA_W-1:0] write_data;
      logic [LEN_W-1:0]  drain_length;
   } cmd_type;

endpackage

// ----- hdl/asrd_if.sv -----
interface asrd_req_if;
   import asrd_pkg::*;

   logic              valid;
   logic              ready;
   logic [ACT_W-1:0]  action;
   logic [IDX_W-1:0]  reg_index;
   logic [ADDR_W-1:0] buf_address;
   logic [DATA_W-1:0] write_data;
   logic [LEN_W-1:0]  drain_length;

   modport source (
      output valid, action, reg_index, buf_address, write_data, drain_length,
      input  ready
   );
   modport sink (
      input  valid, action, reg_index, buf_address, write_data, drain_length,
      output ready
   );
endinterface

interface asrd_rsp_if;
   import asrd_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] read_data;
   logic [BYTE_W-1:0] sample_byte;
   logic              sample_from_buffer;
   logic              last;

   modport source (
      output valid, read_data, sample_byte, sample_from_buffer, last,
      input  ready
   );
   modport sink (
      input  valid, read_data, sample_byte, sample_from_buffer, last,
      output ready
   );
endinterface

// ----- hdl/audio_stream_ring_device.sv -----
// Channel  Dir  Beat contents
// req_ch   in   action, reg_index, buf_address, write_data, drain_length
// rsp_ch   out  read_data, sample_byte, sample_from_buffer, last
//
// Writes retire in the back part with no response beat; a read beat taken from the command queue
// passes the buffer read port (read stage), then the output register.
// A drain of N beats has a setup step when the command is taken, then one beat per cycle while
// rsp_ch is not stalled, through the single buffer read port.
// Synchronous reset clears control registers, init flag, read position and the queue;
// buffer contents are undefined until written.
// A four-entry command queue lets req_ch keep accepting while rsp_ch is stalled.
module audio_stream_ring_device #(
   parameter int unsigned BUFFER_BYTES = asrd_pkg::DEF_BUFFER_BYTES,
   parameter int unsigned MAX_DRAIN    = asrd_pkg::DEF_MAX_DRAIN
) (
   input logic         clock,
   input logic         reset,
   asrd_req_if.sink    req_ch,
   asrd_rsp_if.source  rsp_ch
);
   import asrd_pkg::*;

   logic    front_valid;
   logic    front_ready;
   cmd_type front_cmd;
   logic    q_valid;
   logic    q_ready;
   cmd_type q_cmd;

   asrd_front #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .MAX_DRAIN    (MAX_DRAIN)
   ) u_front (
      .req_ch    (req_ch),
      .cmd_valid (front_valid),
      .cmd       (front_cmd),
      .cmd_ready (front_ready)
   );

   asrd_cmd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_cmd   (front_cmd),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_cmd    (q_cmd)
   );

   asrd_back #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd_ready (q_ready),
      .cmd       (q_cmd),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ----- hdl/asrd_front.sv -----
module asrd_front #(
   parameter int unsigned BUFFER_BYTES = asrd_pkg::DEF_BUFFER_BYTES,
   parameter int unsigned MAX_DRAIN    = asrd_pkg::DEF_MAX_DRAIN
) (
   asrd_req_if.sink          req_ch,
   output logic              cmd_valid,
   output asrd_pkg::cmd_type cmd,
   input  logic              cmd_ready
);
   import asrd_pkg::*;

   logic keep;
   logic idx_ok;
   logic addr_ok;

   assign idx_ok  = req_ch.reg_index < IDX_W'(NUM_REGS);
   assign addr_ok = 32'(req_ch.buf_address) < 32'(BUFFER_BYTES);

   // Beats that change nothing and return nothing are dropped here.
   always_comb begin
      keep             = 1'b0;
      cmd.op           = OP_ZERO_RD;
      cmd.reg_index    = req_ch.reg_index;
      cmd.buf_address  = req_ch.buf_address;
      cmd.write_data   = req_ch.write_data;
      cmd.drain_length = req_ch.drain_length;
      case (req_ch.action)
         ACT_REG_WR: begin
            keep   = idx_ok;
            cmd.op = OP_REG_WR;
         end
         ACT_REG_RD: begin
            keep   = 1'b1;
            cmd.op = idx_ok ? OP_REG_RD : OP_ZERO_RD;
         end
         ACT_BUF_WR: begin
            keep   = addr_ok;
            cmd.op = OP_BUF_WR;
         end
         ACT_BUF_RD: begin
            keep   = 1'b1;
            cmd.op = addr_ok ? OP_BUF_RD : OP_ZERO_RD;
         end
         ACT_DRAIN: begin
            keep   = req_ch.drain_length != '0;
            cmd.op = OP_DRAIN;
            if (req_ch.drain_length > LEN_W'(MAX_DRAIN)) begin
               cmd.drain_length = LEN_W'(MAX_DRAIN);
            end
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign cmd_valid    = req_ch.valid && keep;
   assign req_ch.ready = cmd_ready;

endmodule

// ----- hdl/asrd_cmd_fifo.sv -----
module asrd_cmd_fifo #(
   parameter int unsigned DEPTH = asrd_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  asrd_pkg::cmd_type push_cmd,
   output logic              pop_valid,
   input  logic              pop_ready,
   output asrd_pkg::cmd_type pop_cmd
);
   import asrd_pkg::*;

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   cmd_type         entries_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   fill_ff, fill_in;
   logic            push;
   logic            pop;

   assign push_ready = fill_ff != CW'(DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign pop_cmd    = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + CW'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- hdl/asrd_back.sv -----
`include "audio_stream_ring_device_macros.svh"

module asrd_back #(
   parameter int unsigned BUFFER_BYTES = asrd_pkg::DEF_BUFFER_BYTES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  asrd_pkg::cmd_type cmd,
   asrd_rsp_if.source        rsp_ch
);
   import asrd_pkg::*;

   localparam int unsigned AW = $clog2(BUFFER_BYTES);

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } state_type;

   state_type          state_ff, state_in;
   logic [DATA_W-1:0]  regs_ff [NUM_REGS];
   logic [DATA_W-1:0]  regs_in [NUM_REGS];
   logic               init_ff, init_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic [LEN_W-1:0]   cnt_ff, cnt_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [LEN_W-1:0]   take_ff, take_in;

   // read stage: holds one beat while the buffer read completes
   logic               s1_valid_ff, s1_valid_in;
   logic [DATA_W-1:0]  s1_rd_ff, s1_rd_in;
   logic               s1_bufrd_ff, s1_bufrd_in;
   logic               s1_from_buf_ff, s1_from_buf_in;
   logic               s1_last_ff, s1_last_in;
   logic [BYTE_W-1:0]  mem_q_ff;

   // output register
   logic               out_valid_ff, out_valid_in;
   logic [DATA_W-1:0]  out_rd_ff, out_rd_in;
   logic [BYTE_W-1:0]  out_byte_ff, out_byte_in;
   logic               out_from_buf_ff, out_from_buf_in;
   logic               out_last_ff, out_last_in;

   logic [BYTE_W-1:0]  stream_buf_ff [BUFFER_BYTES];
   logic               mem_we;
   logic [AW-1:0]      mem_wa;
   logic [AW-1:0]      mem_ra;

   logic               o_load;
   logic               s1_free;
   logic               issue;
   logic               issue_last;
   logic [DATA_W-1:0]  init_val;

   assign o_load  = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign s1_free = !s1_valid_ff || o_load;
   assign mem_wa  = AW'(cmd.buf_address);

   always_comb begin
      state_in        = state_ff;
      regs_in         = regs_ff;
      init_in         = init_ff;
      pos_in          = pos_ff;
      cnt_in          = cnt_ff;
      len_in          = len_ff;
      take_in         = take_ff;
      s1_valid_in     = s1_valid_ff;
      s1_rd_in        = s1_rd_ff;
      s1_bufrd_in     = s1_bufrd_ff;
      s1_from_buf_in  = s1_from_buf_ff;
      s1_last_in      = s1_last_ff;
      out_valid_in    = out_valid_ff;
      out_rd_in       = out_rd_ff;
      out_byte_in     = out_byte_ff;
      out_from_buf_in = out_from_buf_ff;
      out_last_in     = out_last_ff;
      cmd_ready       = 1'b0;
      issue           = 1'b0;
      issue_last      = 1'b0;
      mem_we          = 1'b0;
      mem_ra          = pos_ff;
      init_val        = regs_ff[IDX_INIT];

      if (o_load) begin
         out_valid_in    = 1'b1;
         out_rd_in       = s1_bufrd_ff ? DATA_W'(mem_q_ff) : s1_rd_ff;
         out_byte_in     = s1_from_buf_ff ? mem_q_ff : '0;
         out_from_buf_in = s1_from_buf_ff;
         out_last_in     = s1_last_ff;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.op)
                  OP_REG_WR: begin
                     cmd_ready               = 1'b1;
                     regs_in[cmd.reg_index]  = cmd.write_data;
                     if (cmd.reg_index == IDX_W'(IDX_INIT)) begin
                        init_val = cmd.write_data;
                     end
                     // first write that leaves init nonzero starts the ring
                     if (init_val != '0 && !init_ff) begin
                        init_in            = 1'b1;
                        regs_in[IDX_COUNT] = '0;
                        regs_in[IDX_SIZE]  = DATA_W'(BUFFER_BYTES);
                     end
                  end
                  OP_BUF_WR: begin
                     cmd_ready = 1'b1;
                     mem_we    = 1'b1;
                  end
                  OP_REG_RD, OP_ZERO_RD, OP_BUF_RD: begin
                     if (s1_free) begin
                        cmd_ready      = 1'b1;
                        issue          = 1'b1;
                        issue_last     = 1'b1;
                        mem_ra         = AW'(cmd.buf_address);
                        s1_rd_in       = (cmd.op == OP_REG_RD) ? regs_ff[cmd.reg_index] : '0;
                        s1_bufrd_in    = cmd.op == OP_BUF_RD;
                        s1_from_buf_in = 1'b0;
                     end
                  end
                  OP_DRAIN: begin
                     cmd_ready = 1'b1;
                     len_in    = cmd.drain_length;
                     cnt_in    = '0;
                     take_in   = '0;
                     if (init_ff) begin
                        take_in = (regs_ff[IDX_COUNT] < DATA_W'(cmd.drain_length)) ?
                                  regs_ff[IDX_COUNT][LEN_W-1:0] : cmd.drain_length;
                     end
                     regs_in[IDX_COUNT] = regs_ff[IDX_COUNT] - DATA_W'(take_in);
                     state_in           = ST_DRAIN;
                  end
                  default: begin
                     cmd_ready = 1'b1;
                  end
               endcase
            end
         end
         ST_DRAIN: begin
            if (s1_free) begin
               issue          = 1'b1;
               issue_last     = (cnt_ff + LEN_W'(1)) == len_ff;
               mem_ra         = pos_ff;
               s1_rd_in       = '0;
               s1_bufrd_in    = 1'b0;
               s1_from_buf_in = cnt_ff < take_ff;
               cnt_in         = cnt_ff + LEN_W'(1);
               if (cnt_ff < take_ff) begin
                  pos_in = (pos_ff == AW'(BUFFER_BYTES - 1)) ? '0 : pos_ff + AW'(1);
               end
               if (issue_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (issue) begin
         s1_valid_in = 1'b1;
         s1_last_in  = issue_last;
      end else if (o_load) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         regs_ff      <= '{default: '0};
         init_ff      <= 1'b0;
         pos_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         regs_ff      <= regs_in;
         init_ff      <= init_in;
         pos_ff       <= pos_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      cnt_ff          <= cnt_in;
      len_ff          <= len_in;
      take_ff         <= take_in;
      s1_rd_ff        <= s1_rd_in;
      s1_bufrd_ff     <= s1_bufrd_in;
      s1_from_buf_ff  <= s1_from_buf_in;
      s1_last_ff      <= s1_last_in;
      out_rd_ff       <= out_rd_in;
      out_byte_ff     <= out_byte_in;
      out_from_buf_ff <= out_from_buf_in;
      out_last_ff     <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stream_buf_ff[mem_wa] <= cmd.write_data[BYTE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         mem_q_ff <= stream_buf_ff[mem_ra];
      end
   end

   assign rsp_ch.valid              = out_valid_ff;
   assign rsp_ch.read_data          = out_rd_ff;
   assign rsp_ch.sample_byte        = out_byte_ff;
   assign rsp_ch.sample_from_buffer = out_from_buf_ff;
   assign rsp_ch.last               = out_last_ff;

   `ASRD_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !o_load, s1_valid_ff && $stable(s1_last_ff))
   `ASRD_ASSERT(a_drain_bounds, clock, reset, state_ff == ST_DRAIN, take_ff <= len_ff && cnt_ff < len_ff)
   `ASRD_ASSERT_NEXT(a_drain_end, clock, reset, state_ff == ST_DRAIN && issue && issue_last, state_ff == ST_IDLE)
   `ASRD_ASSERT(a_no_pop_in_drain, clock, reset, state_ff == ST_DRAIN, !cmd_ready)
   `ASRD_ASSERT_NEXT(a_init_sticky, clock, reset, init_ff, init_ff)

endmodule

// ----- tb/audio_ring_checker.sv -----
module audio_ring_checker
   import asrd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   asrd_req_if         req_ch,
   asrd_rsp_if         rsp_ch,
   output int unsigned mismatches,
   output int unsigned owed_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic [BYTE_W-1:0] sample_byte;
      logic              from_buffer;
      logic              last;
   } rsp_beat_type;

   // Shadow of the device: control registers, init flag, playback pointer, sample store.
   logic [DATA_W-1:0] ctl_regs [NUM_REGS];
   logic              armed;
   int unsigned       play_pos;
   logic [BYTE_W-1:0] ring [DEF_BUFFER_BYTES];
   rsp_beat_type      owed_beats [$];

   function automatic rsp_beat_type make_beat(input logic [DATA_W-1:0] rd,
                                              input logic [BYTE_W-1:0] sb,
                                              input logic fb, input logic lst);
      return '{rd, sb, fb, lst};
   endfunction

   task automatic predict_access(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx,
                                 input logic [ADDR_W-1:0] addr,
                                 input logic [DATA_W-1:0] data,
                                 input logic [LEN_W-1:0] len);
      int unsigned n;
      int unsigned take;
      int unsigned k;
      case (act)
         ACT_REG_WR: begin
            if (idx < NUM_REGS) begin
               ctl_regs[idx] = data;
               // init latches on the first write that leaves the init register nonzero
               if (ctl_regs[IDX_INIT] != '0 && !armed) begin
                  armed = 1'b1;
                  ctl_regs[IDX_COUNT] = '0;
                  ctl_regs[IDX_SIZE] = DEF_BUFFER_BYTES;
               end
            end
         end
         ACT_REG_RD: begin
            owed_beats.push_back(make_beat(idx < NUM_REGS ? ctl_regs[idx] : '0,
                                           '0, 1'b0, 1'b1));
         end
         ACT_BUF_WR: begin
            if (addr < DEF_BUFFER_BYTES) ring[addr] = data[BYTE_W-1:0];
         end
         ACT_BUF_RD: begin
            owed_beats.push_back(make_beat(addr < DEF_BUFFER_BYTES ? DATA_W'(ring[addr]) : '0,
                                           '0, 1'b0, 1'b1));
         end
         ACT_DRAIN: begin
            if (len != '0) begin
               n = (len > DEF_MAX_DRAIN) ? DEF_MAX_DRAIN : len;
               take = 0;
               if (armed) take = (ctl_regs[IDX_COUNT] < n) ? ctl_regs[IDX_COUNT] : n;
               for (k = 0; k < n; k++) begin
                  if (k < take) begin
                     owed_beats.push_back(make_beat('0, ring[play_pos], 1'b1, k + 1 == n));
                     play_pos = (play_pos + 1) % DEF_BUFFER_BYTES;
                  end else begin
                     owed_beats.push_back(make_beat('0, '0, 1'b0, k + 1 == n));
                  end
               end
               ctl_regs[IDX_COUNT] = ctl_regs[IDX_COUNT] - take;
            end
         end
         default: ;
      endcase
   endtask

   task automatic report(input string what, input rsp_beat_type want, input rsp_beat_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s: expected rd=%h byte=%h buf=%b last=%b, got rd=%h byte=%h buf=%b last=%b",
                  $time, what, want.read_data, want.sample_byte, want.from_buffer, want.last,
                  got.read_data, got.sample_byte, got.from_buffer, got.last);
   endtask

   always @(posedge clock) begin
      rsp_beat_type got;
      rsp_beat_type want;
      if (reset) begin
         foreach (ctl_regs[i]) ctl_regs[i] = '0;
         armed = 1'b0;
         play_pos = 0;
         mismatches = 0;
         owed_beats.delete();
      end else begin
         // responses first: a beat can never answer a request taken on the same edge
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.read_data, rsp_ch.sample_byte, rsp_ch.sample_from_buffer,
                    rsp_ch.last};
            if (owed_beats.size() == 0) begin
               report("unexpected beat", '0, got);
            end else begin
               want = owed_beats.pop_front();
               if (got.read_data !== want.read_data || got.sample_byte !== want.sample_byte ||
                   got.from_buffer !== want.from_buffer || got.last !== want.last)
                  report("beat mismatch", want, got);
            end
         end
         if (req_ch.valid && req_ch.ready)
            predict_access(req_ch.action, req_ch.reg_index, req_ch.buf_address,
                           req_ch.write_data, req_ch.drain_length);
      end
      owed_count <= owed_beats.size();
   end

endmodule

// ----- tb/tb_audio_stream_ring_device.sv -----
module tb_audio_stream_ring_device;
   timeunit 1ns;
   timeprecision 1ps;
   import asrd_pkg::*;

   localparam logic [IDX_W-1:0] IDX_FREQ        = 3'd0;
   localparam logic [IDX_W-1:0] IDX_TOP         = 3'd7;
   localparam logic [ACT_W-1:0] ACT_SPARE_FIRST = 3'd5;
   localparam logic [ACT_W-1:0] ACT_SPARE_LAST  = 3'd7;
   localparam int unsigned      FILL_BYTES      = 96;
   localparam int unsigned      COUNT_STEP      = 10;
   localparam int unsigned      FIRST_COUNT     = 8;
   localparam int unsigned      PHASE_ITEMS     = 60;

   logic        clock = 1'b0;
   logic        reset;
   int unsigned mismatches;
   int unsigned owed_count;
   int unsigned send_idle_pct;
   int unsigned rsp_stall_pct;
   int unsigned count_budget;
   int unsigned idle_plan [4]  = '{0, 77, 0, 20};
   int unsigned stall_plan [4] = '{0, 0, 77, 20};

   asrd_req_if req_ch ();
   asrd_rsp_if rsp_ch ();

   audio_stream_ring_device uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   audio_ring_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .mismatches (mismatches),
      .owed_count (owed_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Called right after a rising edge; returns on the edge that takes the beat.
   task automatic push_access(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx,
                              input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data,
                              input logic [LEN_W-1:0] len);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.action       <= act;
      req_ch.reg_index    <= idx;
      req_ch.buf_address  <= addr;
      req_ch.write_data   <= data;
      req_ch.drain_length <= len;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic random_access();
      logic [ACT_W-1:0]  act;
      logic [IDX_W-1:0]  idx;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
      logic [LEN_W-1:0]  len;
      int unsigned       roll;
      idx  = IDX_W'($urandom_range(7));
      addr = ADDR_W'($urandom);
      data = $urandom;
      len  = LEN_W'($urandom_range(1, DEF_MAX_DRAIN));
      roll = $urandom_range(99);
      if (roll < 16) begin
         act = ACT_REG_WR;
         if ($urandom_range(1) == 1) idx = IDX_W'(IDX_COUNT);
      end else if (roll < 26) begin
         act = ACT_REG_RD;
      end else if (roll < 38) begin
         act = ACT_BUF_WR;
      end else if (roll < 50) begin
         act = ACT_BUF_RD;
         // only the prefilled bytes are read back
         addr = ADDR_W'($urandom_range(FILL_BYTES - 1));
      end else if (roll < 95) begin
         act = ACT_DRAIN;
         if ($urandom_range(9) == 0) len = LEN_W'($urandom_range(127));
      end else begin
         act = ACT_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
      end
      // small counts, bounded in sum, keep the play pointer inside the prefilled bytes
      if (act == ACT_REG_WR && idx == IDX_W'(IDX_COUNT)) begin
         data = $urandom_range((count_budget < COUNT_STEP) ? count_budget : COUNT_STEP);
         count_budget = count_budget - data;
      end
      push_access(act, idx, addr, data, len);
   endtask

   task automatic wait_quiet();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (owed_count != 0) @(posedge clock);
   endtask

   initial begin
      int unsigned k;
      int unsigned ph;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.action       = ACT_REG_WR;
      req_ch.reg_index    = '0;
      req_ch.buf_address  = '0;
      req_ch.write_data   = '0;
      req_ch.drain_length = '0;
      send_idle_pct       = 0;
      rsp_stall_pct       = 0;
      count_budget        = FILL_BYTES - FIRST_COUNT;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // registers before init, drains that can only pad, ignored indexes and actions
      push_access(ACT_REG_RD, IDX_COUNT, '0, '0, '0);
      push_access(ACT_REG_RD, IDX_TOP, '0, '0, '0);
      push_access(ACT_REG_WR, IDX_FREQ, '0, '1, '0);
      push_access(ACT_REG_RD, IDX_FREQ, '0, '0, '0);
      push_access(ACT_REG_WR, IDX_TOP, '1, '1, '1);
      push_access(ACT_REG_WR, IDX_W'(NUM_REGS), '0, '1, '0);
      push_access(ACT_REG_RD, IDX_W'(NUM_REGS), '0, '0, '0);
      push_access(ACT_REG_WR, IDX_COUNT, '0, '1, '0);
      push_access(ACT_DRAIN, '0, '0, '0, LEN_W'(DEF_MAX_DRAIN));
      push_access(ACT_DRAIN, '1, '1, '1, '0);
      push_access(ACT_DRAIN, '0, '0, '0, '1);
      push_access(ACT_REG_RD, IDX_COUNT, '0, '0, '0);
      push_access(ACT_SPARE_FIRST, '1, '1, '1, '1);
      push_access(ACT_SPARE_LAST, '1, '1, '1, '1);
      push_access(ACT_BUF_WR, '0, '0, '1, '0);
      push_access(ACT_BUF_WR, '0, '1, 32'h0000_00a5, '0);
      push_access(ACT_BUF_RD, '0, '0, '0, '0);
      push_access(ACT_BUF_RD, '0, '1, '0, '0);
      // zero init value must not arm; the next nonzero one does
      push_access(ACT_REG_WR, IDX_INIT, '0, '0, '0);
      push_access(ACT_REG_WR, IDX_INIT, '0, 32'h8000_0000, '0);
      push_access(ACT_REG_RD, IDX_SIZE, '0, '0, '0);
      push_access(ACT_REG_RD, IDX_COUNT, '0, '0, '0);
      push_access(ACT_REG_RD, IDX_INIT, '0, '0, '0);
      push_access(ACT_DRAIN, '0, '0, '0, 7'd1);
      wait_quiet();

      // prefill the bytes that the play pointer and buffer reads can reach
      for (k = 0; k < FILL_BYTES; k++)
         push_access(ACT_BUF_WR, '0, ADDR_W'(k), $urandom, '0);
      // a few samples, then padding up to a full drain
      push_access(ACT_REG_WR, IDX_COUNT, '0, DATA_W'(FIRST_COUNT), '0);
      push_access(ACT_DRAIN, '0, '0, '0, LEN_W'(DEF_MAX_DRAIN));
      push_access(ACT_REG_RD, IDX_COUNT, '0, '0, '0);
      wait_quiet();

      for (ph = 0; ph < 4; ph++) begin
         send_idle_pct = idle_plan[ph];
         rsp_stall_pct = stall_plan[ph];
         repeat (PHASE_ITEMS) random_access();
         wait_quiet();
      end

      repeat (80) @(posedge clock);
      if (mismatches == 0 && owed_count == 0)
         $display("audio_stream_ring_device test passed");
      else
         $display("audio_stream_ring_device test failed");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("audio_stream_ring_device test failed");
      $finish;
   end

endmodule
